@@ src/atrf_pkg.sv @@
// ----------------------------------------------------------------------------
// atrf_pkg: shared types and constants of the transmit request framer
// Header layout, length limits, sequencer phase codes and the result word.
// ----------------------------------------------------------------------------
package atrf_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned PhaseW    = 5;
  localparam int unsigned HdrBytes  = 17;

  localparam logic [ByteW-1:0] StartDelim = 8'h7E;
  localparam logic [ByteW-1:0] FrameType  = 8'h10;
  localparam logic [ByteW-1:0] FrameId    = 8'h01;
  localparam logic [ByteW-1:0] DestNetHi  = 8'hFF;
  localparam logic [ByteW-1:0] DestNetLo  = 8'hFE;
  localparam logic [ByteW-1:0] MaxPayload = 8'd237;
  // frame length field = payload + 18 - 4
  localparam logic [ByteW-1:0] LenAdd     = 8'd14;
  // sum of the fixed header bytes from the type byte on, mod 256
  localparam logic [ByteW-1:0] HdrSum     = FrameType + FrameId + DestNetHi + DestNetLo;

  // header byte positions
  localparam logic [PhaseW-1:0] HdrIdxDelim = 5'd0;
  localparam logic [PhaseW-1:0] HdrIdxLen   = 5'd2;
  localparam logic [PhaseW-1:0] HdrIdxType  = 5'd3;
  localparam logic [PhaseW-1:0] HdrIdxId    = 5'd4;
  localparam logic [PhaseW-1:0] HdrIdxNetHi = 5'd13;
  localparam logic [PhaseW-1:0] HdrIdxNetLo = 5'd14;

  // sequencer phases after the header bytes
  localparam logic [PhaseW-1:0] PhData  = 5'(HdrBytes);
  localparam logic [PhaseW-1:0] PhCksum = 5'(HdrBytes + 1);

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             frame_end;
    logic             run_last;
  } word_t;

  function automatic logic [ByteW-1:0] clamp_len(input logic [ByteW-1:0] len);
    logic [ByteW-1:0] res;
    res = len;
    if (len > MaxPayload) begin
      res = MaxPayload;
    end else if (len == '0) begin
      res = 8'd1;
    end
    return res;
  endfunction

  function automatic logic [ByteW-1:0] hdr_byte(input logic [PhaseW-1:0] idx,
                                                input logic [ByteW-1:0] len);
    logic [ByteW-1:0] res;
    res = '0;
    unique case (idx)
      HdrIdxDelim: res = StartDelim;
      HdrIdxLen:   res = clamp_len(len) + LenAdd;
      HdrIdxType:  res = FrameType;
      HdrIdxId:    res = FrameId;
      HdrIdxNetHi: res = DestNetHi;
      HdrIdxNetLo: res = DestNetLo;
      default:     res = '0;
    endcase
    return res;
  endfunction

endpackage

@@ src/atrf_core.sv @@
// ----------------------------------------------------------------------------
// atrf_core: item register and frame sequencer
// Holds one input word, steps it through header, payload and checksum phases
// and keeps the per-frame byte count, length and running sum.
// ----------------------------------------------------------------------------
module atrf_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [atrf_pkg::ByteW-1:0]  in_byte_i,
  input  logic [atrf_pkg::ByteW-1:0]  in_len_i,
  input  logic                        emit_ok_i,
  output logic                        emit_o,
  output atrf_pkg::word_t             word_o
);

  logic                        item_vld_q;
  logic [atrf_pkg::ByteW-1:0]  item_byte_q;
  logic [atrf_pkg::ByteW-1:0]  item_len_q;
  logic [atrf_pkg::PhaseW-1:0] phase_q;

  logic [atrf_pkg::ByteW-1:0]  seen_q, seen_d;
  logic [atrf_pkg::ByteW-1:0]  flen_q, flen_d;
  logic [atrf_pkg::ByteW-1:0]  sum_q, sum_d;

  logic                        fire;
  logic                        finish;
  logic                        accept;
  logic                        in_data;
  logic                        in_cksum;
  logic                        is_last;
  logic [atrf_pkg::ByteW-1:0]  seen_inc;

  assign fire     = item_vld_q && emit_ok_i;
  assign in_data  = (phase_q == atrf_pkg::PhData);
  assign in_cksum = (phase_q == atrf_pkg::PhCksum);
  assign seen_inc = seen_q + 8'd1;
  assign is_last  = (seen_inc >= flen_q);
  assign finish   = fire && ((in_data && !is_last) || in_cksum);
  assign in_ready_o = !item_vld_q || finish;
  assign accept   = in_valid_i && in_ready_o;

  always_comb begin
    seen_d = seen_q;
    flen_d = flen_q;
    sum_d  = sum_q;
    if (fire) begin
      if (phase_q == atrf_pkg::HdrIdxLen) begin
        flen_d = atrf_pkg::clamp_len(item_len_q);
        sum_d  = atrf_pkg::HdrSum;
      end else if (in_data) begin
        sum_d  = sum_q + item_byte_q;
        seen_d = is_last ? '0 : seen_inc;
      end
    end
  end

  always_comb begin
    emit_o         = item_vld_q;
    word_o.data    = atrf_pkg::hdr_byte(phase_q, item_len_q);
    if (in_data) begin
      word_o.data  = item_byte_q;
    end else if (in_cksum) begin
      word_o.data  = ~sum_q;
    end
    word_o.frame_end = in_cksum;
    word_o.run_last  = (in_data && !is_last) || in_cksum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      phase_q    <= '0;
      seen_q     <= '0;
      flen_q     <= '0;
      sum_q      <= '0;
    end else begin
      seen_q <= seen_d;
      flen_q <= flen_d;
      sum_q  <= sum_d;
      if (accept) begin
        item_vld_q <= 1'b1;
        phase_q    <= (seen_d == '0) ? atrf_pkg::HdrIdxDelim : atrf_pkg::PhData;
      end else if (finish) begin
        item_vld_q <= 1'b0;
      end else if (fire) begin
        phase_q    <= phase_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_byte_q <= in_byte_i;
      item_len_q  <= in_len_i;
    end
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q |-> phase_q <= atrf_pkg::PhCksum)
    else $error("sequencer phase out of range");

  a_hdr_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_q && phase_q < atrf_pkg::PhData) |-> seen_q == '0)
    else $error("header emitted mid-frame");

  a_cksum_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_q && in_cksum) |-> seen_q == '0)
    else $error("checksum while frame still open");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flen_q <= atrf_pkg::MaxPayload && seen_q < atrf_pkg::MaxPayload)
    else $error("frame length or byte count out of range");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_q && !emit_ok_i) |=> (item_vld_q && $stable(phase_q)))
    else $error("item lost while output stalled");

endmodule

@@ src/api_tx_request_framer.sv @@
// ----------------------------------------------------------------------------
// api_tx_request_framer: wraps payload bytes into API transmit request frames
//
// Input stream s_axis: one payload byte per word, with the frame's payload
// length beside it. The length is taken only on a frame's first byte and is
// clamped to 1..237. Output stream m_axis: framed bytes, tlast on the closing
// checksum, tuser on the last output word caused by each input word.
// The first byte of a frame yields the 17-byte header, the byte itself and,
// for a one-byte frame, the checksum; later bytes yield the byte and, on the
// last, the checksum.
// An accepted word goes to the item register, then to the output register.
// Throughput: one output word per cycle while m_axis_tready stays high.
// The single output word register sets this: one frame byte leaves per cycle.
// Reset clears the frame state; the block then waits for a frame start.
// When m_axis stalls, the output word holds and s_axis_tready drops once the
// held input word still has bytes to emit; nothing is dropped.
// ----------------------------------------------------------------------------
module api_tx_request_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] payload_byte, [15:8] payload_length
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  output logic        m_axis_tlast,   // frame_end
  output logic        m_axis_tuser    // [0] run_last
);

  logic            out_vld_q;
  atrf_pkg::word_t out_q;
  logic            load_ok;
  logic            emit;
  atrf_pkg::word_t word;

  assign load_ok = !out_vld_q || m_axis_tready;

  atrf_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata[7:0]),
    .in_len_i   (s_axis_tdata[15:8]),
    .emit_ok_i  (load_ok),
    .emit_o     (emit),
    .word_o     (word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_ok) begin
      out_vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok && emit) begin
      out_q <= word;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q.data;
  assign m_axis_tlast  = out_q.frame_end;
  assign m_axis_tuser  = out_q.run_last;

endmodule
